[rtl/rsla_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsla_pkg
// Shared types and constants for the RGB status LED animator: mode codes,
// configuration register indexes, reset values and the colour record.
// ----------------------------------------------------------------------------
package rsla_pkg;

    // Width of the elapsed-time counter (13..32)
    localparam int TIMER_BITS = 16;
    localparam logic [TIMER_BITS-1:0] ELAPSED_MAX = '1;

    // Mode codes as carried on the input channel
    localparam logic [2:0] MODE_CODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_CODE_SEARCH = 3'd1;
    localparam logic [2:0] MODE_CODE_STROBE = 3'd2;
    localparam logic [2:0] MODE_CODE_STEADY = 3'd3;
    localparam logic [2:0] MODE_CODE_FAIL   = 3'd4;

    // Transaction command codes
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SET_MODE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_BRIGHTNESS    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WHEEL_STEP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_STROBE_ON     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_STROBE_OFF    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_STROBE_BLINKS = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_FAIL_HALF     = 3'd5;

    // Configuration reset values
    localparam logic [7:0]  RST_BRIGHTNESS    = 8'd255;
    localparam logic [9:0]  RST_WHEEL_STEP    = 10'd15;
    localparam logic [11:0] RST_STROBE_ON     = 12'd150;
    localparam logic [11:0] RST_STROBE_OFF    = 12'd150;
    localparam logic [3:0]  RST_STROBE_BLINKS = 4'd5;
    localparam logic [11:0] RST_FAIL_HALF     = 12'd300;

    // Strobe sub-phases
    localparam logic [7:0] STROBE_PH_START = 8'd0;
    localparam logic [7:0] STROBE_PH_ON    = 8'd1;
    localparam logic [7:0] STROBE_PH_OFF   = 8'd2;

    // Colour wheel segment bounds and full intensity
    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;
    localparam logic [7:0] FULL_ON    = 8'd255;

    // Internal display mode, one-hot
    typedef enum logic [4:0] {
        MODE_OFF    = 5'b00001,
        MODE_SEARCH = 5'b00010,
        MODE_STROBE = 5'b00100,
        MODE_STEADY = 5'b01000,
        MODE_FAIL   = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0]  brightness;
        logic [9:0]  wheel_step_ms;
        logic [11:0] strobe_on_ms;
        logic [11:0] strobe_off_ms;
        logic [3:0]  strobe_blinks;
        logic [11:0] fail_half_ms;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] level;
    } colour_t;

endpackage
`default_nettype wire

[rtl/rsla_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsla_cfg
// Configuration register bank: six timing and brightness registers written
// through a plain indexed write port.
// ----------------------------------------------------------------------------
module rsla_cfg (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [rsla_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [rsla_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output rsla_pkg::cfg_t                             cfg
);

    rsla_pkg::cfg_t cfg_reg;
    rsla_pkg::cfg_t cfg_next;

    // Decode the write; indexes beyond the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rsla_pkg::CFG_IDX_BRIGHTNESS:    cfg_next.brightness    = cfg_data[7:0];
                rsla_pkg::CFG_IDX_WHEEL_STEP:    cfg_next.wheel_step_ms = cfg_data[9:0];
                rsla_pkg::CFG_IDX_STROBE_ON:     cfg_next.strobe_on_ms  = cfg_data[11:0];
                rsla_pkg::CFG_IDX_STROBE_OFF:    cfg_next.strobe_off_ms = cfg_data[11:0];
                rsla_pkg::CFG_IDX_STROBE_BLINKS: cfg_next.strobe_blinks = cfg_data[3:0];
                rsla_pkg::CFG_IDX_FAIL_HALF:     cfg_next.fail_half_ms  = cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.brightness    <= rsla_pkg::RST_BRIGHTNESS;
            cfg_reg.wheel_step_ms <= rsla_pkg::RST_WHEEL_STEP;
            cfg_reg.strobe_on_ms  <= rsla_pkg::RST_STROBE_ON;
            cfg_reg.strobe_off_ms <= rsla_pkg::RST_STROBE_OFF;
            cfg_reg.strobe_blinks <= rsla_pkg::RST_STROBE_BLINKS;
            cfg_reg.fail_half_ms  <= rsla_pkg::RST_FAIL_HALF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[rtl/rsla_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsla_engine
// Animation state and next-state logic: mode, phase, elapsed timer, blink
// count and red toggle. Produces at most one colour per transaction.
// ----------------------------------------------------------------------------
module rsla_engine (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic            cmd,
    input  wire logic [2:0]      mode,
    input  wire rsla_pkg::cfg_t  cfg,
    output logic                 res_valid,
    output rsla_pkg::colour_t    res
);

    localparam int TB = rsla_pkg::TIMER_BITS;

    rsla_pkg::mode_t  cur_mode_reg, cur_mode_next;
    logic [7:0]       phase_reg, phase_next;
    logic [TB-1:0]    elapsed_reg, elapsed_next;
    logic [3:0]       blink_count_reg, blink_count_next;
    logic             red_on_reg, red_on_next;

    rsla_pkg::mode_t  req_mode;
    logic             req_known;
    logic [TB-1:0]    elapsed_inc;
    logic [7:0]       phase_inc;
    logic [3:0]       blink_inc;
    logic [23:0]      rgb;

    // Colour wheel: three linear segments split at 85 and 170
    function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] tri3;
        begin
            if (pos < rsla_pkg::WHEEL_SEG1) begin
                p = pos;
            end else if (pos < rsla_pkg::WHEEL_SEG2) begin
                p = pos - rsla_pkg::WHEEL_SEG1;
            end else begin
                p = pos - rsla_pkg::WHEEL_SEG2;
            end
            tri3 = {p[6:0], 1'b0} + p;
            if (pos < rsla_pkg::WHEEL_SEG1) begin
                wheel_rgb = {tri3, rsla_pkg::FULL_ON - tri3, 8'd0};
            end else if (pos < rsla_pkg::WHEEL_SEG2) begin
                wheel_rgb = {rsla_pkg::FULL_ON - tri3, 8'd0, tri3};
            end else begin
                wheel_rgb = {8'd0, tri3, rsla_pkg::FULL_ON - tri3};
            end
        end
    endfunction

    // Map the requested mode code onto the one-hot mode
    always_comb begin
        req_known = 1'b1;
        case (mode)
            rsla_pkg::MODE_CODE_OFF:    req_mode = rsla_pkg::MODE_OFF;
            rsla_pkg::MODE_CODE_SEARCH: req_mode = rsla_pkg::MODE_SEARCH;
            rsla_pkg::MODE_CODE_STROBE: req_mode = rsla_pkg::MODE_STROBE;
            rsla_pkg::MODE_CODE_STEADY: req_mode = rsla_pkg::MODE_STEADY;
            rsla_pkg::MODE_CODE_FAIL:   req_mode = rsla_pkg::MODE_FAIL;
            default: begin
                req_mode  = rsla_pkg::MODE_OFF;
                req_known = 1'b0;
            end
        endcase
    end

    assign elapsed_inc = (elapsed_reg == rsla_pkg::ELAPSED_MAX) ? elapsed_reg
                                                                : elapsed_reg + 1'b1;
    assign phase_inc   = phase_reg + 8'd1;
    assign blink_inc   = blink_count_reg + 4'd1;

    // Next state and result for one transaction
    always_comb begin
        cur_mode_next    = cur_mode_reg;
        phase_next       = phase_reg;
        elapsed_next     = elapsed_reg;
        blink_count_next = blink_count_reg;
        red_on_next      = red_on_reg;
        res_valid        = 1'b0;
        rgb              = 24'd0;

        if (cmd == rsla_pkg::CMD_SET_MODE) begin
            // Enter a new mode; unknown codes and the current mode are dropped
            if (req_known && (req_mode != cur_mode_reg)) begin
                cur_mode_next    = req_mode;
                phase_next       = 8'd0;
                blink_count_next = 4'd0;
                elapsed_next     = rsla_pkg::ELAPSED_MAX;
                if (req_mode == rsla_pkg::MODE_OFF) begin
                    res_valid = 1'b1;
                end else if (req_mode == rsla_pkg::MODE_STEADY) begin
                    res_valid = 1'b1;
                    rgb       = {8'd0, rsla_pkg::FULL_ON, 8'd0};
                end
            end
        end else begin
            elapsed_next = elapsed_inc;
            case (cur_mode_reg)
                rsla_pkg::MODE_SEARCH: begin
                    if (elapsed_inc >= TB'(cfg.wheel_step_ms)) begin
                        elapsed_next = '0;
                        phase_next   = phase_inc;
                        res_valid    = 1'b1;
                        rgb          = wheel_rgb(phase_inc);
                    end
                end
                rsla_pkg::MODE_STROBE: begin
                    if (phase_reg == rsla_pkg::STROBE_PH_START) begin
                        phase_next   = rsla_pkg::STROBE_PH_ON;
                        elapsed_next = '0;
                        res_valid    = 1'b1;
                        rgb          = {8'd0, rsla_pkg::FULL_ON, 8'd0};
                    end else if (phase_reg == rsla_pkg::STROBE_PH_ON) begin
                        if (elapsed_inc >= TB'(cfg.strobe_on_ms)) begin
                            phase_next   = rsla_pkg::STROBE_PH_OFF;
                            elapsed_next = '0;
                            res_valid    = 1'b1;
                        end
                    end else if (phase_reg == rsla_pkg::STROBE_PH_OFF) begin
                        if (elapsed_inc >= TB'(cfg.strobe_off_ms)) begin
                            if (blink_inc >= cfg.strobe_blinks) begin
                                // Blinks done: settle on steady green
                                cur_mode_next    = rsla_pkg::MODE_STEADY;
                                phase_next       = 8'd0;
                                blink_count_next = 4'd0;
                                elapsed_next     = rsla_pkg::ELAPSED_MAX;
                                res_valid        = 1'b1;
                                rgb              = {8'd0, rsla_pkg::FULL_ON, 8'd0};
                            end else begin
                                blink_count_next = blink_inc;
                                phase_next       = rsla_pkg::STROBE_PH_START;
                            end
                        end
                    end
                end
                rsla_pkg::MODE_FAIL: begin
                    if (elapsed_inc >= TB'(cfg.fail_half_ms)) begin
                        elapsed_next = '0;
                        red_on_next  = !red_on_reg;
                        res_valid    = 1'b1;
                        rgb          = {(red_on_reg ? 8'd0 : rsla_pkg::FULL_ON), 16'd0};
                    end
                end
                default: ;
            endcase
        end
    end

    assign res.red   = rgb[23:16];
    assign res.green = rgb[15:8];
    assign res.blue  = rgb[7:0];
    assign res.level = cfg.brightness;

    // Advance state only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode_reg    <= rsla_pkg::MODE_OFF;
            phase_reg       <= 8'd0;
            elapsed_reg     <= rsla_pkg::ELAPSED_MAX;
            blink_count_reg <= 4'd0;
            red_on_reg      <= 1'b0;
        end else if (accept) begin
            cur_mode_reg    <= cur_mode_next;
            phase_reg       <= phase_next;
            elapsed_reg     <= elapsed_next;
            blink_count_reg <= blink_count_next;
            red_on_reg      <= red_on_next;
        end
    end

    // Unknown mode codes never give a colour
    a_unknown_mode_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == rsla_pkg::CMD_SET_MODE && !req_known) |-> !res_valid)
        else $error("colour produced for an unknown mode code");

    // Outside searching the phase stays within the strobe sub-phases
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_mode_reg != rsla_pkg::MODE_SEARCH) |-> (phase_reg <= rsla_pkg::STROBE_PH_OFF))
        else $error("phase out of range outside searching mode");

    // A fail-mode colour always flips the red flag
    a_fail_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == rsla_pkg::CMD_TICK && cur_mode_reg == rsla_pkg::MODE_FAIL
         && res_valid) |=> (red_on_reg != $past(red_on_reg)))
        else $error("fail colour emitted without red toggle");

endmodule
`default_nettype wire

[rtl/rsla_out.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsla_out
// Result register: holds one colour until the downstream side takes it and
// frees itself in the same cycle it is drained.
// ----------------------------------------------------------------------------
module rsla_out (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire logic               load_valid,
    input  wire rsla_pkg::colour_t  load_data,
    output logic                    space,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rsla_pkg::colour_t       m_data
);

    logic              valid_reg, valid_next;
    rsla_pkg::colour_t data_reg, data_next;

    // Room for a new transaction when empty or being drained now
    assign space = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = load_valid;
            data_next  = load_data;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // Never overwrite a colour still waiting downstream
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!valid_reg || m_ready))
        else $error("result register overwritten while held");

endmodule
`default_nettype wire

[rtl/rgb_status_led_animator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_status_led_animator
// RGB status LED animator: turns millisecond ticks and set-mode commands
// into colour transactions with the global brightness attached.
//
//   Channel   Direction  Handshake         Payload
//   s_        in         s_valid/s_ready   s_cmd, s_mode
//   m_        out        m_valid/m_ready   m_red, m_green, m_blue, m_level
//   cfg_      in         cfg_wr_en         cfg_index, cfg_data
//
// One transaction per cycle while s_ready is high: next state and colour
// are formed in one pass, and the colour lands in the result register on
// the accepting edge. s_ready is high while the result register is empty
// or being drained. A stalled m_ side holds s_ready low only while a
// colour is waiting. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_status_led_animator (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_cmd,
    input  wire logic [2:0]                            s_mode,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [7:0]                                 m_red,
    output logic [7:0]                                 m_green,
    output logic [7:0]                                 m_blue,
    output logic [7:0]                                 m_level,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [rsla_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [rsla_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    rsla_pkg::cfg_t    cfg;
    rsla_pkg::colour_t res;
    rsla_pkg::colour_t m_data;
    logic              res_valid;
    logic              space;
    logic              accept;

    assign s_ready = space;
    assign accept  = s_valid && space;

    rsla_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsla_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cmd       (s_cmd),
        .mode      (s_mode),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    rsla_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .load_valid (res_valid),
        .load_data  (res),
        .space      (space),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    assign m_red   = m_data.red;
    assign m_green = m_data.green;
    assign m_blue  = m_data.blue;
    assign m_level = m_data.level;

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB status LED animator. A behavioural model
// of the mode, phase, timer, blink and red-toggle state predicts each colour
// transaction. Directed runs cover mode commands, zero and maximum periods,
// the full wheel and the blink limit. Randomised traffic then runs under
// three register settings, two of them with sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int          STALL_LIMIT   = 4000;
    localparam int          DRAIN_WAIT    = 10;
    localparam int          EXTREME_TICKS = 40;
    localparam int          DATA_W        = rsla_pkg::CFG_DATA_BITS;
    localparam logic [7:0]  DARK          = 8'd0;

    // Clock, reset and block ports
    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    logic                                s_cmd     = rsla_pkg::CMD_TICK;
    logic [2:0]                          s_mode    = rsla_pkg::MODE_CODE_OFF;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    logic [7:0]                          m_red;
    logic [7:0]                          m_green;
    logic [7:0]                          m_blue;
    logic [7:0]                          m_level;
    logic                                cfg_wr_en = 1'b0;
    logic [rsla_pkg::CFG_IDX_BITS-1:0]   cfg_index = rsla_pkg::CFG_IDX_BRIGHTNESS;
    logic [DATA_W-1:0]                   cfg_data  = '0;

    // Predicted LED state and register copy
    rsla_pkg::cfg_t led_cfg = {rsla_pkg::RST_BRIGHTNESS, rsla_pkg::RST_WHEEL_STEP,
                               rsla_pkg::RST_STROBE_ON, rsla_pkg::RST_STROBE_OFF,
                               rsla_pkg::RST_STROBE_BLINKS, rsla_pkg::RST_FAIL_HALF};
    logic [2:0]                      led_mode    = rsla_pkg::MODE_CODE_OFF;
    logic [7:0]                      led_phase   = '0;
    logic [rsla_pkg::TIMER_BITS-1:0] led_elapsed = rsla_pkg::ELAPSED_MAX;
    logic [3:0]                      led_blinks  = '0;
    logic                            red_lit     = 1'b0;

    rsla_pkg::colour_t colour_q[$];
    rsla_pkg::colour_t due;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int items_in      = 0;
    int colours_out   = 0;
    int settings_used = 0;
    int stall_cycles  = 0;

    rgb_status_led_animator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_mode    (s_mode),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_red     (m_red),
        .m_green   (m_green),
        .m_blue    (m_blue),
        .m_level   (m_level),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Colour prediction
    // ------------------------------------------------------------------
    function automatic rsla_pkg::colour_t paint(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
        rsla_pkg::colour_t c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        c.level = led_cfg.brightness;
        return c;
    endfunction

    // Three segments: red rises over green, blue over red, green over blue
    function automatic rsla_pkg::colour_t wheel_colour(input logic [7:0] pos);
        logic [7:0] p;
        if (pos < rsla_pkg::WHEEL_SEG1) begin
            p = 8'(pos * 3);
            return paint(p, rsla_pkg::FULL_ON - p, DARK);
        end
        if (pos < rsla_pkg::WHEEL_SEG2) begin
            p = 8'((pos - rsla_pkg::WHEEL_SEG1) * 3);
            return paint(rsla_pkg::FULL_ON - p, DARK, p);
        end
        p = 8'((pos - rsla_pkg::WHEEL_SEG2) * 3);
        return paint(DARK, p, rsla_pkg::FULL_ON - p);
    endfunction

    // Entering a mode clears phase and count and saturates the timer
    function automatic logic enter_mode(input logic [2:0] code,
                                        output rsla_pkg::colour_t col);
        led_mode    = code;
        led_phase   = '0;
        led_blinks  = '0;
        led_elapsed = rsla_pkg::ELAPSED_MAX;
        col         = '0;
        if (code == rsla_pkg::MODE_CODE_OFF) begin
            col = paint(DARK, DARK, DARK);
            return 1'b1;
        end
        if (code == rsla_pkg::MODE_CODE_STEADY) begin
            col = paint(DARK, rsla_pkg::FULL_ON, DARK);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic led_predict(input logic cmd, input logic [2:0] code,
                                         output rsla_pkg::colour_t col);
        col = '0;
        if (cmd == rsla_pkg::CMD_SET_MODE) begin
            if (code > rsla_pkg::MODE_CODE_FAIL || code == led_mode)
                return 1'b0;
            return enter_mode(code, col);
        end
        if (led_elapsed != rsla_pkg::ELAPSED_MAX)
            led_elapsed = led_elapsed + 1'b1;
        case (led_mode)
            rsla_pkg::MODE_CODE_SEARCH: begin
                if (led_elapsed < led_cfg.wheel_step_ms)
                    return 1'b0;
                led_elapsed = '0;
                led_phase   = led_phase + 8'd1;
                col = wheel_colour(led_phase);
                return 1'b1;
            end
            rsla_pkg::MODE_CODE_STROBE: begin
                case (led_phase)
                    rsla_pkg::STROBE_PH_START: begin
                        led_phase   = rsla_pkg::STROBE_PH_ON;
                        led_elapsed = '0;
                        col = paint(DARK, rsla_pkg::FULL_ON, DARK);
                        return 1'b1;
                    end
                    rsla_pkg::STROBE_PH_ON: begin
                        if (led_elapsed < led_cfg.strobe_on_ms)
                            return 1'b0;
                        led_phase   = rsla_pkg::STROBE_PH_OFF;
                        led_elapsed = '0;
                        col = paint(DARK, DARK, DARK);
                        return 1'b1;
                    end
                    rsla_pkg::STROBE_PH_OFF: begin
                        if (led_elapsed < led_cfg.strobe_off_ms)
                            return 1'b0;
                        led_blinks = led_blinks + 4'd1;
                        if (led_blinks >= led_cfg.strobe_blinks)
                            return enter_mode(rsla_pkg::MODE_CODE_STEADY, col);
                        led_phase = rsla_pkg::STROBE_PH_START;
                        return 1'b0;
                    end
                    default: return 1'b0;
                endcase
            end
            rsla_pkg::MODE_CODE_FAIL: begin
                if (led_elapsed < led_cfg.fail_half_ms)
                    return 1'b0;
                led_elapsed = '0;
                red_lit     = ~red_lit;
                col = paint(red_lit ? rsla_pkg::FULL_ON : DARK, DARK, DARK);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    // Compare each colour transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            colours_out++;
            if (colour_q.size() == 0) begin
                report_mismatch($sformatf("unexpected colour r=%0d g=%0d b=%0d l=%0d",
                                          m_red, m_green, m_blue, m_level));
            end else begin
                due = colour_q.pop_front();
                if (m_red !== due.red)
                    report_mismatch($sformatf("red got %0d want %0d", m_red, due.red));
                if (m_green !== due.green)
                    report_mismatch($sformatf("green got %0d want %0d", m_green, due.green));
                if (m_blue !== due.blue)
                    report_mismatch($sformatf("blue got %0d want %0d", m_blue, due.blue));
                if (m_level !== due.level)
                    report_mismatch($sformatf("level got %0d want %0d", m_level, due.level));
            end
        end
    end

    // Stall the result side at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles, %0d colours pending",
                         STALL_LIMIT, colour_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [2:0] code);
        rsla_pkg::colour_t col;
        logic              hit;
        // Idle with valid low for a random stretch
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_mode  <= code;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        hit = led_predict(cmd, code, col);
        if (hit)
            colour_q.push_back(col);
        items_in++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(rsla_pkg::CMD_TICK, 3'($urandom_range(7)));
    endtask

    // Drop valid and wait for every predicted colour plus pipeline slack
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (colour_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic rsla_pkg::cfg_t make_cfg(input logic [7:0] bright,
                                                input logic [9:0] wheel,
                                                input logic [11:0] on_ms,
                                                input logic [11:0] off_ms,
                                                input logic [3:0] blinks,
                                                input logic [11:0] fail_ms);
        rsla_pkg::cfg_t c;
        c.brightness    = bright;
        c.wheel_step_ms = wheel;
        c.strobe_on_ms  = on_ms;
        c.strobe_off_ms = off_ms;
        c.strobe_blinks = blinks;
        c.fail_half_ms  = fail_ms;
        return c;
    endfunction

    // Write all six registers while the block is idle
    task automatic program_config(input rsla_pkg::cfg_t c);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= rsla_pkg::CFG_IDX_BRIGHTNESS;
        cfg_data  <= DATA_W'(c.brightness);
        @(posedge aclk);
        cfg_index <= rsla_pkg::CFG_IDX_WHEEL_STEP;
        cfg_data  <= DATA_W'(c.wheel_step_ms);
        @(posedge aclk);
        cfg_index <= rsla_pkg::CFG_IDX_STROBE_ON;
        cfg_data  <= DATA_W'(c.strobe_on_ms);
        @(posedge aclk);
        cfg_index <= rsla_pkg::CFG_IDX_STROBE_OFF;
        cfg_data  <= DATA_W'(c.strobe_off_ms);
        @(posedge aclk);
        cfg_index <= rsla_pkg::CFG_IDX_STROBE_BLINKS;
        cfg_data  <= DATA_W'(c.strobe_blinks);
        @(posedge aclk);
        cfg_index <= rsla_pkg::CFG_IDX_FAIL_HALF;
        cfg_data  <= DATA_W'(c.fail_half_ms);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        led_cfg = c;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: repeated and unknown modes, entry colours, first tick
    task automatic test_mode_commands();
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_OFF);
        send_item(rsla_pkg::CMD_SET_MODE, 3'd5);
        send_item(rsla_pkg::CMD_SET_MODE, 3'd7);
        send_item(rsla_pkg::CMD_TICK, 3'd7);
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_STEADY);
        send_item(rsla_pkg::CMD_TICK, rsla_pkg::MODE_CODE_OFF);
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_FAIL);
        send_ticks(2);
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_SEARCH);
        send_ticks(1);
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_STROBE);
        send_ticks(1);
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_OFF);
    endtask

    // Zero periods act on every tick; zero blink count ends after one blink
    task automatic test_zero_settings();
        program_config(make_cfg(8'd0, 10'd0, 12'd0, 12'd0, 4'd0, 12'd0));
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_STROBE);
        send_ticks(3);
        // Red toggle state carries over from the earlier fail run
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_FAIL);
        send_ticks(2);
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_SEARCH);
        send_ticks(2);
    endtask

    // Step the whole wheel past its wrap, then strobe up to the largest blink count
    task automatic test_wheel_and_blinks();
        program_config(make_cfg(8'h5A, 10'd1, 12'd1, 12'd1, 4'd15, 12'd1));
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_SEARCH);
        send_ticks(256 + 2);
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_STROBE);
        send_ticks(15 * 3 + 3);
    endtask

    // Largest periods: the first tick acts at once, the following ones wait
    task automatic test_period_extremes();
        program_config(make_cfg(8'd255, 10'd1023, 12'd4095, 12'd4095, 4'd1, 12'd4095));
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_SEARCH);
        send_ticks(EXTREME_TICKS);
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_STROBE);
        send_ticks(EXTREME_TICKS);
        send_item(rsla_pkg::CMD_SET_MODE, rsla_pkg::MODE_CODE_FAIL);
        send_ticks(EXTREME_TICKS);
    endtask

    // Mostly ticks with short periods, mode changes now and then
    task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
        int         done;
        logic       cmd;
        logic [2:0] code;
        done = 0;
        program_config(make_cfg(8'($urandom_range(255)), 10'($urandom_range(1, 4)),
                                12'($urandom_range(1, 6)), 12'($urandom_range(1, 6)),
                                4'($urandom_range(1, 4)), 12'($urandom_range(1, 8))));
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        while (done < count) begin
            cmd  = ($urandom_range(23) == 0) ? rsla_pkg::CMD_SET_MODE : rsla_pkg::CMD_TICK;
            code = 3'($urandom_range(7));
            if (cmd == rsla_pkg::CMD_SET_MODE && $urandom_range(2) != 0) begin
                case ($urandom_range(2))
                    0:       code = rsla_pkg::MODE_CODE_SEARCH;
                    1:       code = rsla_pkg::MODE_CODE_STROBE;
                    default: code = rsla_pkg::MODE_CODE_FAIL;
                endcase
            end
            // Ignored commands do not count toward the item budget
            if (!(cmd == rsla_pkg::CMD_SET_MODE &&
                  (code > rsla_pkg::MODE_CODE_FAIL || code == led_mode)))
                done++;
            send_item(cmd, code);
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_mode_commands();
        test_zero_settings();
        test_wheel_and_blinks();
        test_period_extremes();
        test_random_traffic(250, 10, 63);
        test_random_traffic(250, 63, 10);
        test_random_traffic(250, 0, 0);

        // Drain outstanding colours and allow for the output register
        s_valid <= 1'b0;
        @(posedge aclk);
        while (colour_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Run covered %0d input and %0d colour transactions over %0d register settings,",
                 items_in, colours_out, settings_used);
        $display("with mode commands, all period extremes and both-side stalls.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
